FILE: design/dotq_pkg.sv
// shared types and constants of the deadline ordered task queue
// no dependencies; imported by every module of the block
package dotq_pkg;

  localparam int MAX_TASKS = 16;
  localparam int ID_BITS   = 8;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int DL_W      = 64;
  localparam int ORD_W     = 16;
  localparam int TID_W     = 8;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PICK = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_DUP       = 3'd3,
    STAT_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  // one stored task
  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [DL_W-1:0]    deadline;
    logic [ORD_W-1:0]   order;
  } entry_t;

  // entry memory access, one read and one write port
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } ram_req_t;

  // latched operation
  typedef struct packed {
    op_t                op;
    logic [ID_BITS-1:0] id;
    logic [DL_W-1:0]    deadline;
  } op_req_t;

  typedef struct packed {
    status_t          status;
    logic             picked_valid;
    logic [TID_W-1:0] picked_id;
    logic [DL_W-1:0]  picked_deadline;
    logic [CNT_W-1:0] running_count;
  } result_t;

endpackage

FILE: design/dotq_entry_ram.sv
// task entry memory: one write port, one read port with registered data
// depends on dotq_pkg for the entry layout and depth
module dotq_entry_ram
  import dotq_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output entry_t   rd_data
);

  entry_t mem [MAX_TASKS];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/dotq_engine.sv
// operation sequencer: scans the entry memory once per operation (a no-op skips the scan), then commits
// depends on dotq_pkg; drives dotq_entry_ram through a ram_req_t
module dotq_engine
  import dotq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  op_t                start_op,
  input  logic [TID_W-1:0]   start_id,
  input  logic [DL_W-1:0]    start_rel,
  input  logic [DL_W-1:0]    start_now,
  output logic               idle,
  output ram_req_t           ram_req,
  input  entry_t             ram_rd_data,
  output logic               res_valid,
  input  logic               res_ready,
  output result_t            res
);

  state_t             state_r, state_nxt;
  op_req_t            req_r;
  logic [CNT_W-1:0]   scan_cnt_r, scan_cnt_nxt;
  logic               rd_pend_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               found_r;
  logic [IDX_W-1:0]   found_idx_r;
  logic               best_valid_r;
  logic [DL_W-1:0]    best_dl_r;
  logic [ORD_W-1:0]   best_age_r;
  logic [ID_BITS-1:0] best_id_r;
  logic [MAX_TASKS-1:0] valid_r;
  logic [ORD_W-1:0]   seq_r;
  logic [CNT_W-1:0]   count_r;

  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic [ORD_W-1:0]   rd_age;
  logic               rd_live;
  logic               rd_better;
  logic               do_enq, do_deq, commit;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign rd_live   = rd_pend_r && valid_r[rd_idx_r];
  assign rd_age    = seq_r - ram_rd_data.order;
  assign rd_better = !best_valid_r || (ram_rd_data.deadline < best_dl_r) ||
                     ((ram_rd_data.deadline == best_dl_r) && (rd_age > best_age_r));

  assign commit = (state_r == S_COMMIT) && res_ready;
  assign do_enq = commit && (req_r.op == OP_ENQ) && !found_r && free_found;
  assign do_deq = commit && (req_r.op == OP_DEQ) && found_r;

  // next state
  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        scan_cnt_nxt = '0;
        if (start) begin
          state_nxt = (start_op == OP_NOP) ? S_COMMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
        if (scan_cnt_r == CNT_W'(MAX_TASKS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    idle              = (state_r == S_IDLE);
    res_valid         = (state_r == S_COMMIT);
    ram_req.rd_en     = (state_r == S_SCAN);
    ram_req.rd_addr   = scan_cnt_r[IDX_W-1:0];
    ram_req.wr_en     = do_enq;
    ram_req.wr_addr   = free_idx;
    ram_req.wr_data.id       = req_r.id;
    ram_req.wr_data.deadline = req_r.deadline;
    ram_req.wr_data.order    = seq_r;

    res                 = '0;
    res.status          = STAT_OK;
    res.running_count   = count_r;
    unique case (req_r.op)
      OP_ENQ: begin
        if (found_r) begin
          res.status = STAT_DUP;
        end else if (!free_found) begin
          res.status = STAT_FULL;
        end else begin
          res.running_count = count_r + CNT_W'(1);
        end
      end
      OP_DEQ: begin
        if (found_r) begin
          res.running_count = count_r - CNT_W'(1);
        end else begin
          res.status = STAT_NOT_FOUND;
        end
      end
      OP_PICK: begin
        if (best_valid_r) begin
          res.picked_valid    = 1'b1;
          res.picked_id       = TID_W'(best_id_r);
          res.picked_deadline = best_dl_r;
        end else begin
          res.status = STAT_EMPTY;
        end
      end
      OP_NOP: res.status = STAT_OK;
      default: res.status = STAT_OK;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      scan_cnt_r <= '0;
      rd_pend_r  <= 1'b0;
      valid_r    <= '0;
      seq_r      <= '0;
      count_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      rd_pend_r  <= (state_r == S_SCAN);
      if (do_enq) begin
        valid_r[free_idx] <= 1'b1;
        seq_r             <= seq_r + ORD_W'(1);
        count_r           <= count_r + CNT_W'(1);
      end else if (do_deq) begin
        valid_r[found_idx_r] <= 1'b0;
        count_r              <= count_r - CNT_W'(1);
      end
    end
  end

  // operation and scan results
  always_ff @(posedge clk) begin
    rd_idx_r <= scan_cnt_r[IDX_W-1:0];
    if (start && (state_r == S_IDLE)) begin
      req_r.op       <= start_op;
      req_r.id       <= start_id[ID_BITS-1:0];
      req_r.deadline <= start_now + start_rel;
      found_r        <= 1'b0;
      best_valid_r   <= 1'b0;
    end else if (rd_live) begin
      if (ram_rd_data.id == req_r.id) begin
        found_r     <= 1'b1;
        found_idx_r <= rd_idx_r;
      end
      if (rd_better) begin
        best_valid_r <= 1'b1;
        best_dl_r    <= ram_rd_data.deadline;
        best_age_r   <= rd_age;
        best_id_r    <= ram_rd_data.id;
      end
    end
  end

endmodule

FILE: design/deadline_ordered_task_queue.sv
// top level of the earliest-deadline-first task queue
// depends on dotq_pkg, dotq_entry_ram and dotq_engine
//
//   input channel in_*: one item per operation. in_tuser carries the opcode
//   (enqueue, dequeue, pick). enqueue stores task_id with deadline
//   now + rel_time (mod 2^64); dequeue removes task_id; pick reports the
//   earliest deadline, older enqueue first on ties, without removing it.
//   result channel out_*: exactly one item per input item, in order, with a
//   status, the picked task and the count of queued tasks afterwards.
//   sequence: enqueue, dequeue and pick read all 16 entries of the entry
//   memory through its single read port, one per cycle, then a drain state
//   takes the last read data and a commit state hands the result on; the
//   next item is taken only once the engine is idle again, so items do not
//   overlap. opcode 3 skips the scan and goes straight to the commit state.
//   reset (rst_n low, synchronous) empties the queue and clears the
//   tie-order sequence; the memory itself is not cleared, entries are
//   tracked by valid flops.
//   back-pressure: the result sits in an output register; a new item is
//   accepted while it waits, and the engine holds its commit until it is free.
module deadline_ordered_task_queue
  import dotq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // task_id[7:0], rel_time[71:8], now[135:72]
  input  logic [1:0]   in_tuser,   // opcode[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [79:0]  out_tdata,  // status[2:0], picked_id[10:3],
                                   // picked_deadline[74:11], running_count[79:75]
  output logic [0:0]   out_tuser   // picked_valid[0]
);

  ram_req_t ram_req;
  entry_t   ram_rd_data;
  logic     eng_idle;
  logic     res_valid;
  logic     res_ready;
  result_t  res;
  logic     in_fire;

  logic     out_valid_r;
  result_t  out_res_r;

  assign in_tready = eng_idle;
  assign in_fire   = in_tvalid && eng_idle;

  dotq_entry_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  dotq_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_fire),
    .start_op    (op_t'(in_tuser)),
    .start_id    (in_tdata[7:0]),
    .start_rel   (in_tdata[71:8]),
    .start_now   (in_tdata[135:72]),
    .idle        (eng_idle),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // output register, free when empty or being taken this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.running_count, out_res_r.picked_deadline,
                       out_res_r.picked_id, 3'(out_res_r.status)};
  assign out_tuser  = out_res_r.picked_valid;

endmodule

FILE: design/dotq_checker.sv
// port-level checks on the result channel of the task queue
// depends on dotq_pkg; bound to deadline_ordered_task_queue below
module dotq_checker
  import dotq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[79:75] <= 5'(MAX_TASKS))
    else $error("running count beyond capacity");

  a_pick_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[2:0] == STAT_OK && out_tdata[79:75] != 5'd0)
    else $error("picked item without ok status or with empty queue");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == STAT_EMPTY |-> !out_tuser[0] && out_tdata[79:75] == 5'd0)
    else $error("empty status on a non-empty queue");

  a_no_pick_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[74:3] == 72'd0)
    else $error("picked fields set without a picked task");

endmodule

bind deadline_ordered_task_queue dotq_checker u_dotq_checker (.*);

FILE: bench/dotq_result_checker.sv
// result checker for the deadline ordered task queue: watches both streams,
// predicts every result from the accepted items and compares field by field
// depends on dotq_pkg for the opcode and status enums and the queue size
`timescale 1ns / 100ps

module dotq_result_checker
  import dotq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [135:0] in_tdata,   // task_id[7:0], rel_time[71:8], now[135:72]
  input  logic [1:0]   in_tuser,   // opcode[1:0]
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [79:0]  out_tdata,  // status[2:0], picked_id[10:3],
                                   // picked_deadline[74:11], running_count[79:75]
  input  logic [0:0]   out_tuser,  // picked_valid[0]
  output int           fail_count,
  output int           pending_count,
  output int           checked_count
);

  typedef struct packed {
    status_t     status;
    logic        pick_hit;
    logic [7:0]  pick_id;
    logic [63:0] pick_deadline;
    logic [4:0]  queued;
  } outcome_t;

  // shadow copy of the ready queue
  logic               slot_used     [MAX_TASKS];
  logic [ID_BITS-1:0] slot_task     [MAX_TASKS];
  logic [63:0]        slot_deadline [MAX_TASKS];
  logic [15:0]        slot_stamp    [MAX_TASKS];
  logic [15:0]        enq_stamp;
  int                 queued_tasks;

  outcome_t outcome_fifo[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    checked_count = 0;
  end

  function automatic int find_task(logic [ID_BITS-1:0] id);
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (slot_used[i] && slot_task[i] == id) return i;
    end
    return -1;
  endfunction

  // applies one operation to the shadow queue and returns its result
  function automatic outcome_t apply_op(op_t op, logic [7:0] id, logic [63:0] rel,
                                        logic [63:0] t_now);
    outcome_t    r;
    int          slot;
    int          best;
    logic [15:0] best_age;
    logic [15:0] age;
    r        = '0;
    r.status = STAT_OK;
    slot     = -1;
    best     = -1;
    best_age = '0;
    case (op)
      OP_ENQ: begin
        // duplicate check wins over the full check
        if (find_task(id[ID_BITS-1:0]) >= 0) begin
          r.status = STAT_DUP;
        end else begin
          for (int i = 0; i < MAX_TASKS; i++) begin
            if (!slot_used[i] && slot < 0) slot = i;
          end
          if (slot < 0) begin
            r.status = STAT_FULL;
          end else begin
            slot_used[slot]     = 1'b1;
            slot_task[slot]     = id[ID_BITS-1:0];
            slot_deadline[slot] = t_now + rel;
            slot_stamp[slot]    = enq_stamp;
            enq_stamp           = enq_stamp + 16'd1;
            queued_tasks++;
          end
        end
      end
      OP_DEQ: begin
        slot = find_task(id[ID_BITS-1:0]);
        if (slot < 0) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          slot_used[slot] = 1'b0;
          queued_tasks--;
        end
      end
      OP_PICK: begin
        // earliest deadline, larger age wins a tie
        for (int i = 0; i < MAX_TASKS; i++) begin
          if (slot_used[i]) begin
            age = enq_stamp - slot_stamp[i];
            if (best < 0 || slot_deadline[i] < slot_deadline[best] ||
                (slot_deadline[i] == slot_deadline[best] && age > best_age)) begin
              best     = i;
              best_age = age;
            end
          end
        end
        if (best < 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.pick_hit      = 1'b1;
          r.pick_id       = 8'(slot_task[best]);
          r.pick_deadline = slot_deadline[best];
        end
      end
      default: ;
    endcase
    r.queued = queued_tasks[4:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      if (fail_count < 10)
        $display("%t mismatch on %s of result %0d: expected %h, got %h",
                 $realtime, name, checked_count, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_TASKS; i++) slot_used[i] = 1'b0;
      enq_stamp    = '0;
      queued_tasks = 0;
      outcome_fifo.delete();
    end else begin
      if (in_tvalid && in_tready)
        outcome_fifo.push_back(apply_op(op_t'(in_tuser), in_tdata[7:0],
                                        in_tdata[71:8], in_tdata[135:72]));
      if (out_tvalid && out_tready) begin
        if (outcome_fifo.size() == 0) begin
          if (fail_count < 10)
            $display("%t result item with nothing expected: %h / %b",
                     $realtime, out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = outcome_fifo.pop_front();
          check_field("status", 64'(want.status), 64'(out_tdata[2:0]));
          check_field("picked_valid", 64'(want.pick_hit), 64'(out_tuser[0]));
          check_field("picked_id", 64'(want.pick_id), 64'(out_tdata[10:3]));
          check_field("picked_deadline", want.pick_deadline, out_tdata[74:11]);
          check_field("running_count", 64'(want.queued), 64'(out_tdata[79:75]));
          checked_count++;
        end
      end
    end
    pending_count = outcome_fifo.size();
  end

endmodule

FILE: bench/deadline_ordered_task_queue_test.sv
// top of the deadline ordered task queue bench: clock, reset, stimulus,
// receiver stalls, watchdog and verdict
// depends on dotq_pkg, the block and dotq_result_checker
`timescale 1ns / 100ps

module deadline_ordered_task_queue_test
  import dotq_pkg::*;
();

  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int STUCK_LIMIT  = 5000;  // cycles with no item moving on either side
  localparam int POOL_SIZE    = 20;    // a bit more ids than slots so the queue can fill
  localparam logic [63:0] ALL_ONES = '1;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;   // task_id[7:0], rel_time[71:8], now[135:72]
  logic [1:0]   in_tuser;   // opcode[1:0]
  logic         out_tvalid;
  logic         out_tready;
  logic [79:0]  out_tdata;  // status[2:0], picked_id[10:3],
                            // picked_deadline[74:11], running_count[79:75]
  logic [0:0]   out_tuser;  // picked_valid[0]

  int fail_count;
  int pending_count;
  int checked_count;

  // stall controls of the sender and the receiver, set by the main sequence
  bit src_gaps     = 1'b1;
  bit sink_gaps    = 1'b1;
  bit hold_pending = 1'b0;

  int          op_seen [4];
  int          stuck_cycles;
  logic [7:0]  id_pool [POOL_SIZE];
  logic [63:0] tie_base;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  deadline_ordered_task_queue u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  dotq_result_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  // offers one item and returns at the edge where it is taken;
  // in_tready is looked at on the falling edge so the sample is stable
  task automatic send_op(op_t op, logic [7:0] id, logic [63:0] rel, logic [63:0] t_now);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {t_now, rel, id};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    op_seen[op]++;
  endtask

  task automatic refill_pool();
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = 8'($urandom_range(0, 255));
    tie_base = {$urandom, $urandom};
  endtask

  // deadline shapes: fully random, clustered ties, wrap past 2^64, extremes
  task automatic pick_times(bit tie_heavy, output logic [63:0] rel,
                            output logic [63:0] t_now);
    case ($urandom_range(0, tie_heavy ? 5 : 3))
      0: begin
        rel   = {$urandom, $urandom};
        t_now = {$urandom, $urandom};
      end
      2: begin
        t_now = ALL_ONES - 64'($urandom_range(0, 15));
        rel   = 64'($urandom_range(0, 31));
      end
      3: begin
        t_now = {$urandom, $urandom};
        rel   = $urandom_range(0, 1) ? '0 : ALL_ONES;
      end
      default: begin
        t_now = tie_base;
        rel   = 64'($urandom_range(0, 3));
      end
    endcase
  endtask

  task automatic run_phase(int count, int enq_pct, int deq_pct, bit tie_heavy);
    op_t         op;
    logic [7:0]  id;
    logic [63:0] rel;
    logic [63:0] t_now;
    int          roll;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < enq_pct) op = OP_ENQ;
      else if (roll < enq_pct + deq_pct) op = OP_DEQ;
      else if (roll < 97) op = OP_PICK;
      else op = OP_NOP;
      // mostly ids from the pool so duplicates, hits and a full queue occur
      if ($urandom_range(0, 9) == 0) id = 8'($urandom_range(0, 255));
      else id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      pick_times(tie_heavy, rel, t_now);
      send_op(op, id, rel, t_now);
    end
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // watchdog: too long with nothing moving on either channel ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", STUCK_LIMIT);
        $display("deadline_ordered_task_queue_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    stuck_cycles = 0;
    foreach (op_seen[i]) op_seen[i] = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_NOP;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty queue corners
    send_op(OP_PICK, 8'd0, '0, '0);                 // pick on empty
    send_op(OP_DEQ, 8'd0, '0, '0);                  // dequeue on empty
    // field extremes, deadline wrap, duplicate, no-op
    send_op(OP_ENQ, 8'd0, '0, '0);
    send_op(OP_ENQ, 8'd255, ALL_ONES, ALL_ONES);
    send_op(OP_ENQ, 8'd0, 64'd9, 64'd9);            // duplicate id
    send_op(OP_NOP, 8'd255, ALL_ONES, ALL_ONES);
    // wraps to deadline 0, ties with id 0 which is older
    send_op(OP_ENQ, 8'd7, 64'd5, ALL_ONES - 64'd4);
    send_op(OP_PICK, 8'd0, '0, '0);
    send_op(OP_DEQ, 8'd0, '0, '0);
    send_op(OP_PICK, 8'd0, '0, '0);
    // fill to capacity, then full and duplicate-while-full
    for (int k = 0; k < MAX_TASKS - 2; k++)
      send_op(OP_ENQ, 8'(100 + k), 64'(k), 64'd1000);
    send_op(OP_ENQ, 8'd200, '0, '0);                // full
    send_op(OP_ENQ, 8'd255, '0, '0);                // duplicate beats full
    send_op(OP_PICK, 8'd0, '0, '0);

    // first random phase drains the directed tasks through the pool
    refill_pool();
    id_pool[0] = 8'd7;
    id_pool[1] = 8'd255;
    for (int k = 0; k < MAX_TASKS - 2; k++) id_pool[2 + k] = 8'(100 + k);
    run_phase(600, 45, 30, 1'b0);

    // long receiver hold-off while the sender keeps pushing
    refill_pool();
    src_gaps     = 1'b0;
    hold_pending = 1'b1;
    run_phase(400, 50, 25, 1'b1);

    // fill-heavy then drain-heavy
    refill_pool();
    src_gaps = 1'b1;
    run_phase(250, 70, 10, 1'b0);
    run_phase(250, 15, 60, 1'b0);

    // closing stretch at full rate
    refill_pool();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    run_phase(400, 45, 30, 1'b1);

    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);

    $display("sent %0d enqueue, %0d dequeue, %0d pick and %0d no-op items",
             op_seen[OP_ENQ], op_seen[OP_DEQ], op_seen[OP_PICK], op_seen[OP_NOP]);
    $display("checked %0d results under sender gaps, receiver stalls and a %0d-cycle hold-off",
             checked_count, HOLD_CYCLES);
    if (fail_count == 0 && pending_count == 0) begin
      $display("deadline_ordered_task_queue_test OK");
    end else begin
      $display("deadline_ordered_task_queue_test NOT OK");
    end
    $finish;
  end

endmodule
